@@ design/bps_pkg.sv @@
package bps_pkg;

	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 8;

	typedef struct packed {
		logic        func;
		logic [7:0]  beeps_per_round;
		logic [15:0] on_ticks;
		logic [15:0] gap_ticks;
		logic [7:0]  round_count;
		logic [15:0] round_gap_ticks;
		logic        hide_on_round_gap;
	} bps_item_t;

	typedef struct packed {
		logic buzzer;
		logic hide_display;
		logic busy_res;
		logic done_res;
	} bps_res_t;

endpackage

@@ design/beep_pattern_sequencer.sv @@
// channel | dir | width          | contents
// s_axis  | in  | tdata 72, user | pattern fields, func in tuser
// m_axis  | out | tdata 8        | buzzer, hide_display, busy_res, done_res
//
// one transaction per clock while the result is not stalled; input register then state update and result register
// an input transaction passes the input register and then the result register before its earliest result transaction
// arst_n clears all sequencer state and both stage valids
// a stalled result holds the input stage; s_axis_tready falls only when both stages are full
module beep_pattern_sequencer
	import bps_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// beeps_per_round, on_ticks, gap_ticks, round_count, round_gap_ticks, hide_on_round_gap,
	// zero pad
	input  logic [S_TDATA_W-1:0] s_axis_tdata,
	// func
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// buzzer, hide_display, busy_res, done_res, zero pad
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic      valid_s1;
	bps_item_t item_s1;
	logic      adv;
	bps_res_t  res;
	logic      out_valid_q;
	bps_res_t  out_q;

	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.func              <= s_axis_tuser;
			item_s1.beeps_per_round   <= s_axis_tdata[7:0];
			item_s1.on_ticks          <= s_axis_tdata[23:8];
			item_s1.gap_ticks         <= s_axis_tdata[39:24];
			item_s1.round_count       <= s_axis_tdata[47:40];
			item_s1.round_gap_ticks   <= s_axis_tdata[63:48];
			item_s1.hide_on_round_gap <= s_axis_tdata[64];
		end
	end

	bps_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, out_q.done_res, out_q.busy_res,
		out_q.hide_display, out_q.buzzer};

endmodule

@@ design/bps_seq.sv @@
module bps_seq
	import bps_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  bps_item_t item,
	output bps_res_t  res
);

	logic        running_q, n_running;
	logic        buzzer_q, n_buzzer;
	logic [15:0] cnt_q, n_cnt;
	logic [7:0]  beep_q, n_beep;
	logic [7:0]  round_q, n_round;
	logic        pause_q, n_pause;
	logic        hide_q, n_hide;
	logic [7:0]  beep_cnt_q, n_beep_cnt;
	logic [15:0] on_q, n_on;
	logic [15:0] gap_q, n_gap;
	logic [7:0]  round_cnt_q, n_round_cnt;
	logic [15:0] rgap_q, n_rgap;
	logic        hide_en_q, n_hide_en;
	logic        done;
	logic [15:0] cnt_inc;
	logic [15:0] gap_lim;

	assign cnt_inc = cnt_q + 16'd1;
	assign gap_lim = pause_q ? rgap_q : gap_q;

	always_comb begin
		n_running   = running_q;
		n_buzzer    = buzzer_q;
		n_cnt       = cnt_q;
		n_beep      = beep_q;
		n_round     = round_q;
		n_pause     = pause_q;
		n_hide      = hide_q;
		n_beep_cnt  = beep_cnt_q;
		n_on        = on_q;
		n_gap       = gap_q;
		n_round_cnt = round_cnt_q;
		n_rgap      = rgap_q;
		n_hide_en   = hide_en_q;
		done        = 1'b0;
		if (item.func == FUNC_START) begin
			n_beep_cnt  = item.beeps_per_round;
			n_on        = item.on_ticks;
			n_gap       = item.gap_ticks;
			n_round_cnt = item.round_count;
			n_rgap      = item.round_gap_ticks;
			n_hide_en   = item.hide_on_round_gap;
			n_beep      = 8'd1;
			n_round     = 8'd1;
			n_running   = 1'b1;
			n_buzzer    = 1'b1;
		end else if (running_q) begin
			n_cnt = cnt_inc;
			if (buzzer_q) begin
				if (cnt_inc > on_q) begin
					n_buzzer = 1'b0;
					n_cnt    = 16'd0;
					if (beep_q < beep_cnt_q) begin
						n_beep = beep_q + 8'd1;
					end else if (round_q < round_cnt_q) begin
						n_beep  = 8'd1;
						n_round = round_q + 8'd1;
						n_pause = 1'b1;
						if (hide_en_q) begin
							n_hide = 1'b1;
						end
					end else begin
						n_running = 1'b0;
						done      = 1'b1;
					end
				end
			end else if (cnt_inc > gap_lim) begin
				if (pause_q) begin
					n_pause = 1'b0;
					n_hide  = 1'b0;
				end
				n_buzzer = 1'b1;
				n_cnt    = 16'd0;
			end
		end
	end

	assign res.buzzer       = n_buzzer;
	assign res.hide_display = n_hide;
	assign res.busy_res     = n_running;
	assign res.done_res     = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= 1'b0;
			buzzer_q    <= 1'b0;
			cnt_q       <= '0;
			beep_q      <= '0;
			round_q     <= '0;
			pause_q     <= 1'b0;
			hide_q      <= 1'b0;
			beep_cnt_q  <= '0;
			on_q        <= '0;
			gap_q       <= '0;
			round_cnt_q <= '0;
			rgap_q      <= '0;
			hide_en_q   <= 1'b0;
		end else if (step) begin
			running_q   <= n_running;
			buzzer_q    <= n_buzzer;
			cnt_q       <= n_cnt;
			beep_q      <= n_beep;
			round_q     <= n_round;
			pause_q     <= n_pause;
			hide_q      <= n_hide;
			beep_cnt_q  <= n_beep_cnt;
			on_q        <= n_on;
			gap_q       <= n_gap;
			round_cnt_q <= n_round_cnt;
			rgap_q      <= n_rgap;
			hide_en_q   <= n_hide_en;
		end
	end

endmodule
